[hw/rtl/dual_envelope_generator_defines.svh]
// ============================================================================
// Dual envelope generator assertion macros
// Shared checking macros for the envelope generator modules.
// ============================================================================
`ifndef DUAL_ENVELOPE_GENERATOR_DEFINES_SVH
`define DUAL_ENVELOPE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define DEG_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("DEG check failed");
// Consequence that must hold in the same cycle as its cause.
`define DEG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("DEG check failed");
// Consequence that must hold in the cycle after its cause.
`define DEG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("DEG check failed");
`else
`define DEG_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define DEG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DEG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/deg_pkg.sv]
// ============================================================================
// Dual envelope generator package
// Command codes, register selects, control structs and the waveform table.
// ============================================================================
package deg_pkg;

    // Bus command codes.
    typedef enum logic [1:0] {
        CMD_ADDR = 2'd0,
        CMD_DATA = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // Register selects.
    localparam logic [4:0] REG_ENV0 = 5'h18;
    localparam logic [4:0] REG_ENV1 = 5'h19;
    localparam logic [4:0] REG_CHEN = 5'h1C;

    // Level that marks a generator as off.
    localparam logic [4:0] LEVEL_OFF = 5'h10;

    // Step positions of the looping part of the envelope.
    localparam logic [5:0] STEP_LAST = 6'h3F;
    localparam logic [5:0] STEP_LOOP = 6'h20;

    // Control word from the top level to one generator.
    typedef struct packed {
        logic       load;
        logic       tick;
        logic [7:0] data;
    } t_gen_ctl;

    // Status from one generator back to the top level.
    typedef struct packed {
        logic ext_clock;
    } t_gen_stat;

    // Waveform value at a given step for each of the eight shapes.
    function automatic logic [3:0] wave_value(input logic [2:0] mode, input logic [5:0] pos);
        logic [3:0] low;
        logic [3:0] w;
        low = pos[3:0];
        w   = 4'h0;
        unique case (mode)
            3'd0: w = 4'h0;
            3'd1: w = 4'hF;
            3'd2: w = (pos[5:4] == 2'b00) ? ~low : 4'h0;
            3'd3: w = ~low;
            3'd4: begin
                if (pos[5]) begin
                    w = 4'h0;
                end else if (pos[4]) begin
                    w = ~low;
                end else begin
                    w = low;
                end
            end
            3'd5: w = pos[4] ? ~low : low;
            3'd6: w = (pos[5:4] == 2'b00) ? low : 4'h0;
            3'd7: w = low;
            default: w = 4'h0;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/dual_envelope_generator.sv]
// An accepted word is held in the input register, then decoded into the level registers.
// Throughput: one word per cycle while the sink takes results; the input register and
// the level registers form a two-stage pipe.
// Reset: synchronous, active low; all settings, positions and levels clear to zero,
// and the block is ready for words as soon as reset is released.
// ============================================================================
// Dual envelope generator
// Decodes bus writes and sample ticks and drives two envelope generators.
// ============================================================================
`include "dual_envelope_generator_defines.svh"

module dual_envelope_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_bus_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_gen0_left,
    output logic [4:0] o_gen0_right,
    output logic [4:0] o_gen1_left,
    output logic [4:0] o_gen1_right
);
    import deg_pkg::*;

    logic       r_in_valid;
    t_cmd       r_cmd;
    logic [7:0] r_bus_value;
    logic [4:0] r_sel;
    logic       r_chen;
    logic       r_out_valid;

    logic       w_advance;
    logic       w_addr_env;
    logic       w_sel_env;
    t_gen_ctl   w_ctl0;
    t_gen_ctl   w_ctl1;
    t_gen_stat  w_stat0;
    t_gen_stat  w_stat1;

    // The input word moves on whenever the result register is free or drained.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd       <= t_cmd'(i_cmd);
            r_bus_value <= i_bus_value;
        end
    end

    // Command decode for both generators.
    always_comb begin
        w_addr_env = (r_bus_value[4:0] == REG_ENV0) || (r_bus_value[4:0] == REG_ENV1);
        w_sel_env  = (r_sel == REG_ENV0) || (r_sel == REG_ENV1);
        w_ctl0     = '0;
        w_ctl1     = '0;
        w_ctl0.data = r_bus_value;
        w_ctl1.data = r_bus_value;
        if (w_advance) begin
            unique case (r_cmd)
                CMD_ADDR: begin
                    w_ctl0.tick = w_addr_env && w_stat0.ext_clock;
                    w_ctl1.tick = w_addr_env && w_stat1.ext_clock;
                end
                CMD_DATA: begin
                    w_ctl0.load = w_sel_env && !r_sel[0];
                    w_ctl1.load = w_sel_env && r_sel[0];
                end
                CMD_TICK: begin
                    w_ctl0.tick = r_chen && !w_stat0.ext_clock;
                    w_ctl1.tick = r_chen && !w_stat1.ext_clock;
                end
                CMD_NONE: begin
                    w_ctl0.tick = 1'b0;
                end
                default: begin
                    w_ctl0.tick = 1'b0;
                end
            endcase
        end
    end

    // Register select and channel enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= 5'd0;
            r_chen <= 1'b0;
        end else if (w_advance) begin
            if (r_cmd == CMD_ADDR) begin
                r_sel <= r_bus_value[4:0];
            end else if (r_cmd == CMD_DATA && r_sel == REG_CHEN) begin
                r_chen <= r_bus_value[0];
            end
        end
    end

    // Result valid; the generator levels themselves form the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    deg_gen u_gen0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl0),
        .o_stat  (w_stat0),
        .o_left  (o_gen0_left),
        .o_right (o_gen0_right)
    );

    deg_gen u_gen1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl1),
        .o_stat  (w_stat1),
        .o_left  (o_gen1_left),
        .o_right (o_gen1_right)
    );

    // A held input word blocks new words until it moves on.
    `DEG_ASSERT_IMP(a_hold_blocks, i_clk, i_rst_n, r_in_valid && !w_advance, !o_in_ready)
    // Every word that moves on produces a result word.
    `DEG_ASSERT_NEXT(a_advance_result, i_clk, i_rst_n, w_advance, o_out_valid)
    // A tick with channels disabled moves no generator.
    `DEG_ASSERT_IMP(a_tick_gated, i_clk, i_rst_n, r_in_valid && r_cmd == CMD_TICK && !r_chen, !w_ctl0.tick && !w_ctl1.tick)
    // A data write loads at most one generator.
    `DEG_ASSERT_ALWAYS(a_one_load, i_clk, i_rst_n, !(w_ctl0.load && w_ctl1.load))

endmodule

[hw/rtl/deg_gen.sv]
// ============================================================================
// Envelope generator channel
// Holds the settings, step position and output levels of one generator.
// ============================================================================
`include "dual_envelope_generator_defines.svh"

module deg_gen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  deg_pkg::t_gen_ctl i_ctl,
    output deg_pkg::t_gen_stat o_stat,
    output logic [4:0]        o_left,
    output logic [4:0]        o_right
);
    import deg_pkg::*;

    logic       r_enable;
    logic [2:0] r_mode;
    logic       r_reverse;
    logic       r_low_res;
    logic       r_ext;
    logic [5:0] r_step;
    logic [4:0] r_left;
    logic [4:0] r_right;

    logic [5:0] n_step;
    logic [3:0] w_mask;
    logic [3:0] w_wave;

    // Next position loops over the upper half once it runs past the end.
    always_comb begin
        n_step = (r_step == STEP_LAST) ? STEP_LOOP : (r_step + 6'd1);
        w_mask = r_low_res ? 4'hE : 4'hF;
        w_wave = wave_value(r_mode, n_step);
    end

    // Settings load on a data write; the levels change only on a tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_mode    <= 3'd0;
            r_reverse <= 1'b0;
            r_low_res <= 1'b0;
            r_ext     <= 1'b0;
            r_step    <= 6'd0;
            r_left    <= 5'd0;
            r_right   <= 5'd0;
        end else if (i_ctl.load) begin
            r_reverse <= i_ctl.data[0];
            r_mode    <= i_ctl.data[3:1];
            r_low_res <= i_ctl.data[4];
            r_ext     <= i_ctl.data[5];
            r_enable  <= i_ctl.data[7];
            r_step    <= 6'd0;
        end else if (i_ctl.tick) begin
            if (r_enable) begin
                r_step <= n_step;
                r_left <= {1'b0, w_wave & w_mask};
                if (r_reverse) begin
                    r_right <= {1'b0, ~w_wave & w_mask};
                end else begin
                    r_right <= {1'b0, w_wave & w_mask};
                end
            end else begin
                r_left  <= LEVEL_OFF;
                r_right <= LEVEL_OFF;
            end
        end
    end

    assign o_stat.ext_clock = r_ext;
    assign o_left           = r_left;
    assign o_right          = r_right;

    // An enabled generator that ticks never sits at step zero afterwards.
    `DEG_ASSERT_NEXT(a_tick_leaves_zero, i_clk, i_rst_n, i_ctl.tick && !i_ctl.load && r_enable, r_step != 6'd0)
    // Load and tick never arrive together.
    `DEG_ASSERT_ALWAYS(a_load_tick_excl, i_clk, i_rst_n, !(i_ctl.load && i_ctl.tick))
    // Levels stay in range: a set top bit means the generator is off.
    `DEG_ASSERT_IMP(a_level_range, i_clk, i_rst_n, r_left[4], r_left == LEVEL_OFF && r_right == LEVEL_OFF)

endmodule

[bench/testbench.sv]
// ============================================================================
// Dual envelope generator testbench
// Drives address writes, data writes and sample ticks into the block, tracks
// both envelopes in a local model and checks every result word field by field.
// ============================================================================
module testbench;
    import deg_pkg::*;

    localparam int WORD_TARGET  = 2000;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;

    // Waveform shapes, in the order of the mode field of a control byte.
    typedef enum logic [2:0] {
        SHAPE_ZERO        = 3'd0,
        SHAPE_FULL        = 3'd1,
        SHAPE_DECAY_ONCE  = 3'd2,
        SHAPE_DECAY_LOOP  = 3'd3,
        SHAPE_TRI_ONCE    = 3'd4,
        SHAPE_TRI_LOOP    = 3'd5,
        SHAPE_ATTACK_ONCE = 3'd6,
        SHAPE_ATTACK_LOOP = 3'd7
    } t_shape;

    // Settings and outputs of one envelope as tracked by the bench.
    typedef struct packed {
        logic       enabled;
        t_shape     shape;
        logic       invert_right;
        logic       coarse;
        logic       ext_clock;
        logic [5:0] pos;
        logic [4:0] left;
        logic [4:0] right;
    } t_envelope;

    // One result word: all four factors.
    typedef struct packed {
        logic [4:0] gen0_left;
        logic [4:0] gen0_right;
        logic [4:0] gen1_left;
        logic [4:0] gen1_right;
    } t_levels;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_cmd;
    logic [7:0] i_bus_value;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [4:0] o_gen0_left;
    logic [4:0] o_gen0_right;
    logic [4:0] o_gen1_left;
    logic [4:0] o_gen1_right;

    t_envelope  env_model [2];
    logic [4:0] model_select;
    logic       model_channels_on;
    t_levels    pending_levels [$];
    int         error_count;
    int         words_sent;
    int         idle_cycles;
    logic       quiet_stretch;

    dual_envelope_generator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_bus_value  (i_bus_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_gen0_left  (o_gen0_left),
        .o_gen0_right (o_gen0_right),
        .o_gen1_left  (o_gen1_left),
        .o_gen1_right (o_gen1_right)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Level of a shape at a given position, before masking.
    function automatic logic [3:0] shape_level(t_shape shape, logic [5:0] pos);
        logic [3:0] phase;
        phase = pos[3:0];
        case (shape)
            SHAPE_FULL:        return 4'hF;
            SHAPE_DECAY_ONCE:  return (pos < 6'd16) ? 4'hF - phase : 4'h0;
            SHAPE_DECAY_LOOP:  return 4'hF - phase;
            SHAPE_TRI_ONCE: begin
                if (pos >= 6'd32) begin
                    return 4'h0;
                end else if (pos >= 6'd16) begin
                    return 4'hF - phase;
                end
                return phase;
            end
            SHAPE_TRI_LOOP:    return pos[4] ? 4'hF - phase : phase;
            SHAPE_ATTACK_ONCE: return (pos < 6'd16) ? phase : 4'h0;
            SHAPE_ATTACK_LOOP: return phase;
            default:           return 4'h0;
        endcase
    endfunction

    function automatic void reset_model();
        env_model[0]      = '0;
        env_model[1]      = '0;
        model_select      = '0;
        model_channels_on = 1'b0;
    endfunction

    // One clock of an envelope: step the position, then recompute both sides.
    function automatic void clock_envelope(int g);
        logic [3:0] level;
        logic [3:0] mask;
        if (env_model[g].enabled) begin
            env_model[g].pos = (env_model[g].pos == STEP_LAST) ? STEP_LOOP
                                                               : env_model[g].pos + 6'd1;
            level = shape_level(env_model[g].shape, env_model[g].pos);
            mask  = env_model[g].coarse ? 4'hE : 4'hF;
            env_model[g].left  = {1'b0, level & mask};
            env_model[g].right = env_model[g].invert_right ? {1'b0, (4'hF - level) & mask}
                                                           : {1'b0, level & mask};
        end else begin
            env_model[g].left  = LEVEL_OFF;
            env_model[g].right = LEVEL_OFF;
        end
    endfunction

    // Applies one accepted word to the model and returns the factors it leaves.
    function automatic t_levels apply_word(t_cmd cmd, logic [7:0] value);
        t_levels lv;
        int      g;
        case (cmd)
            CMD_ADDR: begin
                model_select = value[4:0];
                // Selecting an envelope register clocks the externally clocked envelopes.
                if (model_select == REG_ENV0 || model_select == REG_ENV1) begin
                    for (g = 0; g < 2; g++) begin
                        if (env_model[g].ext_clock) clock_envelope(g);
                    end
                end
            end
            CMD_DATA: begin
                if (model_select == REG_ENV0 || model_select == REG_ENV1) begin
                    g = int'(model_select[0]);
                    env_model[g].invert_right = value[0];
                    env_model[g].shape        = t_shape'(value[3:1]);
                    env_model[g].coarse       = value[4];
                    env_model[g].ext_clock    = value[5];
                    env_model[g].enabled      = value[7];
                    env_model[g].pos          = '0;
                end else if (model_select == REG_CHEN) begin
                    model_channels_on = value[0];
                end
            end
            CMD_TICK: begin
                if (model_channels_on) begin
                    for (g = 0; g < 2; g++) begin
                        if (!env_model[g].ext_clock) clock_envelope(g);
                    end
                end
            end
            default: ;
        endcase
        lv.gen0_left  = env_model[0].left;
        lv.gen0_right = env_model[0].right;
        lv.gen1_left  = env_model[1].left;
        lv.gen1_right = env_model[1].right;
        return lv;
    endfunction

    task automatic check_level(string field, logic [4:0] want, logic [4:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // The sink stalls at random except during the quiet stretch.
    always @(negedge i_clk) begin
        i_out_ready <= quiet_stretch || ($urandom_range(0, 99) >= 7);
    end

    // Input and output monitor: model update, result checks and the watchdog.
    always @(posedge i_clk) begin
        t_levels want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_levels.push_back(apply_word(t_cmd'(i_cmd), i_bus_value));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_levels.size() == 0) begin
                    error_count++;
                    $display("%0t: result expected none actual %0d %0d %0d %0d", $time,
                             o_gen0_left, o_gen0_right, o_gen1_left, o_gen1_right);
                end else begin
                    want = pending_levels.pop_front();
                    check_level("gen0_left", want.gen0_left, o_gen0_left);
                    check_level("gen0_right", want.gen0_right, o_gen0_right);
                    check_level("gen1_left", want.gen1_left, o_gen1_left);
                    check_level("gen1_right", want.gen1_right, o_gen1_right);
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Presents one word and waits until the block takes it.
    task automatic send_word(t_cmd cmd, logic [7:0] value);
        @(negedge i_clk);
        while (!quiet_stretch && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_bus_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Address write; the unused upper bits get random values.
    task automatic select_register(logic [4:0] sel);
        send_word(CMD_ADDR, {3'($urandom_range(0, 7)), sel});
    endtask

    task automatic write_register(logic [4:0] sel, logic [7:0] value);
        select_register(sel);
        send_word(CMD_DATA, value);
    endtask

    // Right after reset all factors read zero, and ticks do nothing while
    // the channels are off.
    task automatic test_power_up_levels();
        send_word(CMD_NONE, 8'hFF);
        send_word(CMD_TICK, 8'h00);
    endtask

    // Channel enable decode and writes to registers that do not exist.
    task automatic test_register_decode();
        write_register(REG_CHEN, 8'hFE);
        send_word(CMD_TICK, 8'hFF);
        write_register(REG_CHEN, 8'h01);
        send_word(CMD_TICK, 8'hAA);
        write_register(5'h00, 8'hFF);
        send_word(CMD_DATA, 8'h55);
    endtask

    // Internal and external clocking, reverse, coarse resolution and disable.
    task automatic test_envelope_clocking();
        write_register(REG_ENV0, 8'hFF);
        write_register(REG_ENV1, 8'h89);
        send_word(CMD_TICK, 8'h00);
        select_register(REG_ENV0);
        select_register(REG_ENV1);
        send_word(CMD_TICK, 8'hFF);
        write_register(REG_ENV1, 8'h00);
        send_word(CMD_TICK, 8'h00);
        write_register(REG_ENV0, 8'h00);
        select_register(REG_ENV0);
        send_word(CMD_TICK, 8'h00);
        write_register(REG_CHEN, 8'h00);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_NONE, 8'h00);
    endtask

    // Programs one envelope, then sends it between 1 and 100 selects, ticks and idle words.
    task automatic run_envelope_sequence();
        logic [7:0] ctrl;
        logic [4:0] env_sel;
        int         len;
        int         sel_odds;
        env_sel = ($urandom_range(0, 1) != 0) ? REG_ENV1 : REG_ENV0;
        ctrl    = 8'($urandom);
        ctrl[7] = ($urandom_range(0, 9) != 0);
        write_register(env_sel, ctrl);
        if ($urandom_range(0, 1) == 0) begin
            write_register(REG_CHEN, {7'($urandom), ($urandom_range(0, 9) != 0)});
        end
        // Externally clocked envelopes get mostly register selects.
        sel_odds = ctrl[5] ? 7 : 2;
        len = $urandom_range(1, 100);
        repeat (len) begin
            if ($urandom_range(0, 9) < sel_odds) begin
                select_register(($urandom_range(0, 1) != 0) ? REG_ENV1 : REG_ENV0);
            end else if ($urandom_range(0, 19) == 0) begin
                send_word(CMD_NONE, 8'($urandom));
            end else begin
                send_word(CMD_TICK, 8'($urandom));
            end
        end
    endtask

    // Mostly well-formed sequences, with short bursts of arbitrary words.
    task automatic test_random_traffic();
        while (words_sent < WORD_TARGET) begin
            quiet_stretch = (words_sent >= 800 && words_sent < 1200);
            if ($urandom_range(0, 9) < 7) begin
                run_envelope_sequence();
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_word(t_cmd'($urandom_range(0, 3)), 8'($urandom));
                end
            end
        end
        quiet_stretch = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_NONE;
        i_bus_value   = '0;
        i_out_ready   = 1'b0;
        error_count   = 0;
        words_sent    = 0;
        idle_cycles   = 0;
        quiet_stretch = 1'b0;
        reset_model();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_up_levels();
        test_register_decode();
        test_envelope_clocking();
        test_random_traffic();

        // Drain the remaining results, then watch for stray words.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
